### hdl/clsp_pkg.sv
// clsp_pkg: shared types, character codes and helpers for the command line splitter.
// No dependencies; used by clsp_core, clsp_queue and command_line_splitter.
package clsp_pkg;

    localparam int VERB_CAP_DEFAULT   = 32;
    localparam int LINE_BYTES_DEFAULT = 1024;
    localparam int QUEUE_DEPTH        = 4;

    // widest position counter (LINE_BYTES up to 65536) and widest verb counter
    localparam int POS_WIDE  = 17;
    localparam int VCNT_WIDE = 7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic KIND_VERB    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADID  = 2'd2,
        ST_NOVERB = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_ID,
        PH_GAP,
        PH_VERB,
        PH_REST,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  verb_char;
        status_t     status;
        logic [31:0] req_id;
        logic [4:0]  verb_length;
        logic [9:0]  rest_offset;
        logic        last;
    } out_t;

    // up to two results per accepted byte: verb echo first, then summary
    typedef struct packed {
        logic verb_v;
        logic sum_v;
        out_t verb;
        out_t sum;
    } push_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_stop(logic [7:0] c);
        return (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [9:0] sat_offset(logic [POS_WIDE-1:0] v);
        return (v > POS_WIDE'(1023)) ? 10'd1023 : v[9:0];
    endfunction

    function automatic logic [4:0] sat_length(logic [VCNT_WIDE-1:0] v);
        return (v > VCNT_WIDE'(31)) ? 5'd31 : v[4:0];
    endfunction

endpackage

### hdl/clsp_core.sv
// clsp_core: per-byte parser state and result formation, one byte per cycle while accept is high.
// Depends on clsp_pkg.
module clsp_core #(
    parameter int VERB_CAP   = clsp_pkg::VERB_CAP_DEFAULT,
    parameter int LINE_BYTES = clsp_pkg::LINE_BYTES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  clsp_pkg::in_t        data,
    output clsp_pkg::push_t      push
);

    localparam int PW = $clog2(LINE_BYTES + 1);
    localparam int VW = $clog2(VERB_CAP);

    clsp_pkg::phase_t  phase_reg, phase_next, phase_mid;
    logic [31:0]       id_reg, id_next, id_mid;
    logic              ovf_reg, ovf_next, ovf_mid;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [VW-1:0]     cnt_reg, cnt_next, cnt_mid;
    logic [PW-1:0]     rest_reg, rest_next, rest_mid;
    clsp_pkg::status_t status_reg, status_next, status_mid;

    logic [7:0]  c;
    logic        c_ws, c_stop, c_digit;
    logic [35:0] prod;
    logic [VW-1:0] cnt_inc;

    // bytes at or past the last usable offset read as NUL
    assign c       = (pos_reg >= PW'(LINE_BYTES - 1)) ? clsp_pkg::CH_NUL : data.ch;
    assign c_ws    = clsp_pkg::is_ws(c);
    assign c_stop  = clsp_pkg::is_stop(c);
    assign c_digit = clsp_pkg::is_digit(c);
    assign prod    = ({4'b0, id_reg} << 3) + ({4'b0, id_reg} << 1) + 36'(c[3:0]);
    assign cnt_inc = cnt_reg + VW'(1);

    // next state
    always_comb
    begin
        phase_mid  = phase_reg;
        id_mid     = id_reg;
        ovf_mid    = ovf_reg;
        cnt_mid    = cnt_reg;
        rest_mid   = rest_reg;
        status_mid = status_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            case (phase_reg)
                clsp_pkg::PH_LEAD:
                begin
                    if (c_ws)
                    begin
                    end
                    else if (c_stop)
                    begin
                        status_mid = clsp_pkg::ST_EMPTY;
                        phase_mid  = clsp_pkg::PH_DONE;
                    end
                    else if (!c_digit)
                    begin
                        status_mid = clsp_pkg::ST_BADID;
                        phase_mid  = clsp_pkg::PH_DONE;
                    end
                    else
                    begin
                        id_mid    = 32'(c[3:0]);
                        phase_mid = clsp_pkg::PH_ID;
                    end
                end
                clsp_pkg::PH_ID:
                begin
                    if (c_digit)
                    begin
                        id_mid = prod[31:0];
                        if (prod[35:32] != 4'd0)
                            ovf_mid = 1'b1;
                    end
                    else if (c_ws)
                    begin
                        if (ovf_reg)
                        begin
                            status_mid = clsp_pkg::ST_BADID;
                            phase_mid  = clsp_pkg::PH_DONE;
                        end
                        else
                            phase_mid = clsp_pkg::PH_GAP;
                    end
                    else if (c_stop)
                    begin
                        status_mid = ovf_reg ? clsp_pkg::ST_BADID : clsp_pkg::ST_NOVERB;
                        phase_mid  = clsp_pkg::PH_DONE;
                    end
                    else
                    begin
                        status_mid = clsp_pkg::ST_BADID;
                        phase_mid  = clsp_pkg::PH_DONE;
                    end
                end
                clsp_pkg::PH_GAP, clsp_pkg::PH_VERB:
                begin
                    if (c_ws)
                    begin
                        if (phase_reg == clsp_pkg::PH_VERB)
                        begin
                            rest_mid  = pos_reg + PW'(1);
                            phase_mid = clsp_pkg::PH_REST;
                        end
                    end
                    else if (c_stop)
                    begin
                        if (phase_reg == clsp_pkg::PH_GAP)
                            status_mid = clsp_pkg::ST_NOVERB;
                        else
                        begin
                            rest_mid   = pos_reg;
                            status_mid = clsp_pkg::ST_OK;
                        end
                        phase_mid = clsp_pkg::PH_DONE;
                    end
                    else
                    begin
                        cnt_mid   = cnt_inc;
                        phase_mid = clsp_pkg::PH_VERB;
                        if (cnt_inc >= VW'(VERB_CAP - 1))
                        begin
                            rest_mid  = pos_reg + PW'(1);
                            phase_mid = clsp_pkg::PH_REST;
                        end
                    end
                end
                clsp_pkg::PH_REST:
                begin
                    if (c_ws)
                        rest_mid = pos_reg + PW'(1);
                    else
                    begin
                        rest_mid   = pos_reg;
                        status_mid = clsp_pkg::ST_OK;
                        phase_mid  = clsp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
            if (pos_reg < PW'(LINE_BYTES))
                pos_next = pos_reg + PW'(1);
        end

        phase_next  = phase_mid;
        id_next     = id_mid;
        ovf_next    = ovf_mid;
        cnt_next    = cnt_mid;
        rest_next   = rest_mid;
        status_next = status_mid;
        // line end: back to the start-of-line state
        if (accept && data.line_end)
        begin
            phase_next  = clsp_pkg::PH_LEAD;
            id_next     = 32'd0;
            ovf_next    = 1'b0;
            cnt_next    = '0;
            rest_next   = '0;
            status_next = clsp_pkg::ST_EMPTY;
            pos_next    = '0;
        end
    end

    // outputs
    always_comb
    begin
        clsp_pkg::status_t st;
        logic [PW-1:0]     rest;

        st   = status_mid;
        rest = rest_mid;
        case (phase_mid)
            clsp_pkg::PH_LEAD: st = clsp_pkg::ST_EMPTY;
            clsp_pkg::PH_ID:   st = ovf_mid ? clsp_pkg::ST_BADID : clsp_pkg::ST_NOVERB;
            clsp_pkg::PH_GAP:  st = clsp_pkg::ST_NOVERB;
            clsp_pkg::PH_VERB:
            begin
                st   = clsp_pkg::ST_OK;
                rest = pos_reg + PW'(1);
            end
            clsp_pkg::PH_REST: st = clsp_pkg::ST_OK;
            default:           st = status_mid;
        endcase

        push.verb_v = accept && ((phase_reg == clsp_pkg::PH_GAP) ||
                                 (phase_reg == clsp_pkg::PH_VERB)) && !c_ws && !c_stop;
        push.sum_v  = accept && data.line_end;

        push.verb.kind        = clsp_pkg::KIND_VERB;
        push.verb.verb_char   = c;
        push.verb.status      = clsp_pkg::ST_OK;
        push.verb.req_id      = 32'd0;
        push.verb.verb_length = 5'd0;
        push.verb.rest_offset = 10'd0;
        push.verb.last        = 1'b0;

        push.sum.kind        = clsp_pkg::KIND_SUMMARY;
        push.sum.verb_char   = 8'd0;
        push.sum.status      = st;
        push.sum.req_id      = ((st == clsp_pkg::ST_OK) || (st == clsp_pkg::ST_NOVERB)) ?
                               id_mid : 32'd0;
        push.sum.verb_length = clsp_pkg::sat_length(clsp_pkg::VCNT_WIDE'(cnt_mid));
        push.sum.rest_offset = (st == clsp_pkg::ST_OK) ?
                               clsp_pkg::sat_offset(clsp_pkg::POS_WIDE'(rest)) : 10'd0;
        push.sum.last        = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= clsp_pkg::PH_LEAD;
            id_reg     <= 32'd0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            rest_reg   <= '0;
            status_reg <= clsp_pkg::ST_EMPTY;
        end
        else
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            ovf_reg    <= ovf_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            rest_reg   <= rest_next;
            status_reg <= status_next;
        end
    end

endmodule

### hdl/clsp_queue.sv
// clsp_queue: small result queue taking up to two entries per cycle, one out per cycle when not stalled.
// Depends on clsp_pkg.
module clsp_queue #(
    parameter int DEPTH = clsp_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  clsp_pkg::push_t push,
    output logic            room,
    output logic            valid,
    input  logic            stall,
    output clsp_pkg::out_t  data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    clsp_pkg::out_t mem [DEPTH];

    logic [AW-1:0] wp_reg, wp_next, wp_inc, wp_inc2, rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [1:0]    npush;

    assign wp_inc  = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign wp_inc2 = (wp_inc == AW'(DEPTH - 1)) ? '0 : wp_inc + AW'(1);
    assign npush   = {1'b0, push.verb_v} + {1'b0, push.sum_v};
    assign pop     = valid && !stall;

    assign room  = (count_reg <= CW'(DEPTH - 2));
    assign valid = (count_reg != '0);
    assign data  = mem[rp_reg];

    always_comb
    begin
        case (npush)
            2'd1:    wp_next = wp_inc;
            2'd2:    wp_next = wp_inc2;
            default: wp_next = wp_reg;
        endcase
        rp_next    = pop ? ((rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1)) : rp_reg;
        count_next = count_reg + CW'(npush) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.verb_v)
            mem[wp_reg] <= push.verb;
        if (push.sum_v && push.verb_v)
            mem[wp_inc] <= push.sum;
        else if (push.sum_v)
            mem[wp_reg] <= push.sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue over capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.verb_v || push.sum_v) |-> room)
        else $error("push without room for two results");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CW'($past(npush)) - CW'($past(pop)))
        else $error("queue count out of step with transfers");

    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && data.kind == clsp_pkg::KIND_SUMMARY) |-> data.last)
        else $error("summary without last");

endmodule

### hdl/command_line_splitter.sv
// command_line_splitter: top level; byte parser feeding a small result queue.
// Depends on clsp_pkg, clsp_core, clsp_queue.
//
//   channel   dir   handshake                   payload
//   line      in    line_valid / line_stall     line_data   (clsp_pkg::in_t)
//   res       out   res_valid  / res_stall      res_data    (clsp_pkg::out_t)
//
// One byte per cycle while line_stall is low. Each byte's parse step runs combinationally
// from the parser state registers into the result queue; results leave one per cycle
// while res_stall is low. A verb byte that also ends the line makes two results.
// line_stall rises only when the queue has fewer than two free entries.
// Async reset (rst_n low) returns the parser to the line start and empties the queue.
module command_line_splitter #(
    parameter int VERB_CAP    = clsp_pkg::VERB_CAP_DEFAULT,
    parameter int LINE_BYTES  = clsp_pkg::LINE_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = clsp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           line_valid,
    output logic           line_stall,
    input  clsp_pkg::in_t  line_data,
    output logic           res_valid,
    input  logic           res_stall,
    output clsp_pkg::out_t res_data
);

    logic            accept;
    logic            room;
    clsp_pkg::push_t push;

    // a byte transfer needs room for its worst case of two results
    assign line_stall = !room;
    assign accept     = line_valid && room;

    clsp_core #(
        .VERB_CAP   (VERB_CAP),
        .LINE_BYTES (LINE_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .data   (line_data),
        .push   (push)
    );

    clsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .valid (res_valid),
        .stall (res_stall),
        .data  (res_data)
    );

endmodule

### test/command_line_splitter_tb.sv
// command_line_splitter_tb: self-checking bench for the command line splitter.
// Depends on clsp_pkg and the command_line_splitter RTL; byte-level predictor inside.
module command_line_splitter_tb;

    localparam int          VERB_LIMIT   = clsp_pkg::VERB_CAP_DEFAULT;
    localparam int          LINE_LIMIT   = clsp_pkg::LINE_BYTES_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic           clk        = 1'b0;
    logic           rst_n      = 1'b0;
    logic           line_valid = 1'b0;
    logic           line_stall;
    clsp_pkg::in_t  line_data  = '0;
    logic           res_valid;
    logic           res_stall  = 1'b0;
    clsp_pkg::out_t res_data;

    command_line_splitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line_data  (line_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // idle / stall odds in percent, set per test
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    logic        hold_active = 1'b0;

    int unsigned err_count  = 0;
    int unsigned sent_bytes = 0;
    int unsigned cycles     = 0;

    clsp_pkg::out_t expected_results[$];
    logic [7:0]     line_buf[$];

    // parser state mirror
    clsp_pkg::phase_t  ph;
    logic [31:0]       id_acc;
    logic              id_ovf;
    int unsigned       lpos;
    int unsigned       vcnt;
    int unsigned       rpos;
    clsp_pkg::status_t lstat;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic blank(logic [7:0] c);
        return c == clsp_pkg::CH_SPACE || c == clsp_pkg::CH_TAB;
    endfunction

    function automatic logic terminator(logic [7:0] c);
        return c == clsp_pkg::CH_NUL || c == clsp_pkg::CH_CR || c == clsp_pkg::CH_LF;
    endfunction

    function automatic logic numeral(logic [7:0] c);
        return c >= clsp_pkg::CH_ZERO && c <= clsp_pkg::CH_NINE;
    endfunction

    task automatic clear_line_state();
        ph     = clsp_pkg::PH_LEAD;
        id_acc = '0;
        id_ovf = 1'b0;
        lpos   = 0;
        vcnt   = 0;
        rpos   = 0;
        lstat  = clsp_pkg::ST_EMPTY;
    endtask

    task automatic conclude(input clsp_pkg::status_t st);
        lstat = st;
        ph    = clsp_pkg::PH_DONE;
    endtask

    task automatic predict_byte(input logic [7:0] ch_in, input logic end_in);
        logic [7:0]        c;
        logic [35:0]       wide;
        int unsigned       pos;
        int unsigned       rest;
        clsp_pkg::status_t st;
        logic [31:0]       id;
        clsp_pkg::out_t    r;
        c   = ch_in;
        pos = lpos;
        // bytes at or past the buffer's last usable slot read as NUL
        if (pos >= LINE_LIMIT - 1)
            c = clsp_pkg::CH_NUL;
        case (ph)
            clsp_pkg::PH_LEAD:
            begin
                if (blank(c))
                    ;
                else if (terminator(c))
                    conclude(clsp_pkg::ST_EMPTY);
                else if (!numeral(c))
                    conclude(clsp_pkg::ST_BADID);
                else
                begin
                    id_acc = 32'(c - clsp_pkg::CH_ZERO);
                    ph     = clsp_pkg::PH_ID;
                end
            end
            clsp_pkg::PH_ID:
            begin
                if (numeral(c))
                begin
                    wide = id_acc * 36'd10 + 36'(c - clsp_pkg::CH_ZERO);
                    if (wide[35:32] != 4'd0)
                        id_ovf = 1'b1;
                    id_acc = wide[31:0];
                end
                else if (blank(c))
                begin
                    if (id_ovf)
                        conclude(clsp_pkg::ST_BADID);
                    else
                        ph = clsp_pkg::PH_GAP;
                end
                else if (terminator(c))
                    conclude(id_ovf ? clsp_pkg::ST_BADID : clsp_pkg::ST_NOVERB);
                else
                    conclude(clsp_pkg::ST_BADID);
            end
            clsp_pkg::PH_GAP, clsp_pkg::PH_VERB:
            begin
                if (blank(c))
                begin
                    if (ph == clsp_pkg::PH_VERB)
                    begin
                        rpos = pos + 1;
                        ph   = clsp_pkg::PH_REST;
                    end
                end
                else if (terminator(c))
                begin
                    if (ph == clsp_pkg::PH_GAP)
                        conclude(clsp_pkg::ST_NOVERB);
                    else
                    begin
                        rpos = pos;
                        conclude(clsp_pkg::ST_OK);
                    end
                end
                else
                begin
                    r           = '0;
                    r.kind      = clsp_pkg::KIND_VERB;
                    r.verb_char = c;
                    expected_results.push_back(r);
                    vcnt++;
                    ph = clsp_pkg::PH_VERB;
                    if (vcnt >= VERB_LIMIT - 1)
                    begin
                        rpos = pos + 1;
                        ph   = clsp_pkg::PH_REST;
                    end
                end
            end
            clsp_pkg::PH_REST:
            begin
                if (blank(c))
                    rpos = pos + 1;
                else
                begin
                    rpos = pos;
                    conclude(clsp_pkg::ST_OK);
                end
            end
            default:
                ;
        endcase
        if (lpos < LINE_LIMIT)
            lpos++;
        if (end_in)
        begin
            id   = '0;
            rest = 0;
            case (ph)
                clsp_pkg::PH_LEAD: st = clsp_pkg::ST_EMPTY;
                clsp_pkg::PH_ID:   st = id_ovf ? clsp_pkg::ST_BADID : clsp_pkg::ST_NOVERB;
                clsp_pkg::PH_GAP:  st = clsp_pkg::ST_NOVERB;
                clsp_pkg::PH_VERB:
                begin
                    st   = clsp_pkg::ST_OK;
                    rpos = pos + 1;
                end
                clsp_pkg::PH_REST: st = clsp_pkg::ST_OK;
                default:           st = lstat;
            endcase
            if (st == clsp_pkg::ST_OK || st == clsp_pkg::ST_NOVERB)
                id = id_acc;
            if (st == clsp_pkg::ST_OK)
                rest = rpos;
            r             = '0;
            r.kind        = clsp_pkg::KIND_SUMMARY;
            r.status      = st;
            r.req_id      = id;
            r.verb_length = (vcnt > 31) ? 5'd31 : 5'(vcnt);
            r.rest_offset = (rest > 1023) ? 10'd1023 : 10'(rest);
            r.last        = 1'b1;
            expected_results.push_back(r);
            clear_line_state();
        end
    endtask

    // ------------------------------------------------------------------
    // line input side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic e);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            line_valid <= 1'b0;
            @(posedge clk);
        end
        line_valid <= 1'b1;
        line_data  <= '{ch: c, line_end: e};
        @(posedge clk);
        while (line_stall !== 1'b0)
            @(posedge clk);
        predict_byte(c, e);
        sent_bytes++;
    endtask

    // sends the buffered line, flagging the last byte as line end
    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        line_buf.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? clsp_pkg::CH_SPACE : clsp_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] pick_terminator();
        int unsigned k;
        k = $urandom_range(0, 2);
        return (k == 0) ? clsp_pkg::CH_NUL : (k == 1) ? clsp_pkg::CH_CR : clsp_pkg::CH_LF;
    endfunction

    function automatic logic [7:0] pick_digit();
        return clsp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_verb_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (blank(c) || terminator(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1:       return pick_digit();
            2:       return pick_blank();
            default: return pick_terminator();
        endcase
    endfunction

    // mostly well-formed lines with random content; some cut short, some noise
    task automatic make_random_line();
        int unsigned pick;
        int unsigned n;
        int unsigned cut;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            repeat ($urandom_range(0, 3)) add_byte(pick_blank());
            n = $urandom_range(0, 9);
            if (n == 0)
                add_str("4294967295");
            else if (n == 1)
                add_str("4294967296");
            else if (n == 2)
                repeat ($urandom_range(11, 14)) add_byte(pick_digit());
            else
                repeat ($urandom_range(1, 9)) add_byte(pick_digit());
            repeat ($urandom_range(1, 3)) add_byte(pick_blank());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 36) : $urandom_range(1, 8);
            repeat (n) add_byte(pick_verb_char());
            repeat ($urandom_range(0, 3)) add_byte(pick_blank());
            repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                add_byte(pick_terminator());
            // broken line: cut at a random point
            if (pick >= 55)
            begin
                cut = $urandom_range(1, line_buf.size());
                while (line_buf.size() > cut)
                    void'(line_buf.pop_back());
            end
        end
        else
            repeat ($urandom_range(1, 12)) add_byte(pick_noise());
    endtask

    // ------------------------------------------------------------------
    // result side: stall driver and checker
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            res_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        err_count++;
    endtask

    initial
    begin
        clsp_pkg::out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual %h",
                             $time, res_data);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data.kind !== want.kind)
                        report_field("kind", 32'(want.kind), 32'(res_data.kind));
                    if (res_data.verb_char !== want.verb_char)
                        report_field("verb_char", 32'(want.verb_char),
                                     32'(res_data.verb_char));
                    if (res_data.status !== want.status)
                        report_field("status", 32'(want.status), 32'(res_data.status));
                    if (res_data.req_id !== want.req_id)
                        report_field("req_id", want.req_id, res_data.req_id);
                    if (res_data.verb_length !== want.verb_length)
                        report_field("verb_length", 32'(want.verb_length),
                                     32'(res_data.verb_length));
                    if (res_data.rest_offset !== want.rest_offset)
                        report_field("rest_offset", 32'(want.rest_offset),
                                     32'(res_data.rest_offset));
                    if (res_data.last !== want.last)
                        report_field("last", 32'(want.last), 32'(res_data.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_lines();
        add_str("   \t ");
        send_line();
        add_byte(clsp_pkg::CH_NUL);
        send_line();
        // stop byte first, trailing bytes ignored
        add_byte(clsp_pkg::CH_CR);
        add_str(" 12 junk");
        send_line();
        add_byte(clsp_pkg::CH_LF);
        send_line();
    endtask

    task automatic test_request_ids();
        add_str("0 a");
        send_line();
        add_str("4294967295 x");
        send_line();
        // one past the top: sticky overflow, bad id
        add_str("4294967296 x");
        send_line();
        add_str("99999999999");
        add_byte(clsp_pkg::CH_LF);
        send_line();
        add_str("12");
        send_line();
        add_str("12 \t ");
        send_line();
        add_str("12x y");
        send_line();
        add_str("abc");
        send_line();
        add_str("12");
        add_byte(clsp_pkg::CH_CR);
        send_line();
    endtask

    task automatic test_verbs();
        add_str("42 GET /a b");
        send_line();
        // verb byte that also ends the line: echo then summary
        add_str("\t7\tab");
        send_line();
        // verb cap: the 31st char closes the verb
        add_str("1 ");
        repeat (35) add_byte(8'h7a);
        add_str(" x");
        send_line();
        add_str("8 ");
        add_byte(8'hff);
        add_byte(8'h80);
        add_byte(8'h01);
        send_line();
        add_str("3 verb  ");
        add_byte(clsp_pkg::CH_LF);
        add_str(" tail");
        send_line();
        add_str("5 v");
        add_byte(clsp_pkg::CH_CR);
        add_str("ignored");
        send_line();
    endtask

    task automatic test_random_lines(input int unsigned idle, input int unsigned stall,
                                     input int unsigned nbytes);
        int unsigned start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = sent_bytes;
        while (sent_bytes - start < nbytes)
        begin
            make_random_line();
            send_line();
        end
    endtask

    // receiver holds off while the sender keeps offering, so the queue fills
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        fork
            begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
        join_none
        add_str("12 ");
        repeat (30) add_byte(pick_verb_char());
        add_str(" tail");
        send_line();
    endtask

    // ------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("command_line_splitter_tb: done, errors");
        $finish;
    end

    initial
    begin
        clear_line_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lines();
        test_request_ids();
        test_verbs();
        test_random_lines(0, 0, 50);
        test_random_lines(48, 0, 50);
        test_random_lines(0, 48, 50);
        test_random_lines(17, 17, 50);
        test_backpressure();

        line_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("command_line_splitter_tb: done, clean");
        else
            $display("command_line_splitter_tb: done, errors");
        $finish;
    end

endmodule
